// ----- rtl/core/flhc_pkg.sv -----
// ----------------------------------------------------------------------------
// flhc_pkg
// shared types and constants of the floating horizon column rasterizer
// ----------------------------------------------------------------------------
package flhc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_ORIGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_ORIGIN = 2'd1;

  localparam logic [CFG_W-1:0] ROW_ORIGIN_RST = 10'd255;
  localparam logic [CFG_W-1:0] COL_ORIGIN_RST = 10'd0;

  localparam logic [8:0] DEPTH_START  = 9'd511;
  localparam logic [9:0] FG_BASE      = 10'd513;
  localparam logic [7:0] RIDGE_MAX    = 8'd254;
  localparam logic [7:0] FG_COLOUR    = 8'd255;
  localparam logic [7:0] ERASE_COLOUR = 8'd0;
  localparam logic [7:0] RIDGE_BIAS   = 8'd2;

  typedef struct packed {
    logic [10:0] col;
    logic [11:0] row;
    logic [10:0] len;
    logic [7:0]  colour;
  } run_t;

  typedef struct packed {
    logic visible;
    logic has_a;
    logic has_b;
    run_t run_a;
    run_t run_b;
  } eval_t;

endpackage

// ----- rtl/core/flhc_interp.sv -----
// ----------------------------------------------------------------------------
// flhc_interp
// shared bilinear accumulator: loads the first sub-column sum, then steps
// ----------------------------------------------------------------------------
module flhc_interp #(
  parameter int SUBCOLUMNS = 3,
  parameter int SUM_W      = 12
) (
  input  logic                    clk,
  input  logic                    start,
  input  logic                    step,
  input  logic [1:0]              p,
  input  logic signed [7:0]       h00,
  input  logic signed [7:0]       h10,
  input  logic signed [7:0]       h01,
  input  logic signed [7:0]       h11,
  output logic signed [SUM_W-1:0] sum
);

  logic signed [3:0]       w0;
  logic signed [3:0]       w1;
  logic signed [8:0]       d0;
  logic signed [8:0]       d1;
  logic signed [11:0]      base;
  logic signed [11:0]      delta;
  logic signed [SUM_W-1:0] init;
  logic signed [SUM_W-1:0] acc_r;
  logic signed [11:0]      dlt_r;

  always_comb begin
    w1    = signed'({2'b00, p});
    w0    = 4'sd4 - w1;
    d0    = 9'(h10) - 9'(h00);
    d1    = 9'(h11) - 9'(h01);
    base  = 12'(h00) * 12'(w0) + 12'(h01) * 12'(w1);
    delta = 12'(d0) * 12'(w0) + 12'(d1) * 12'(w1);
    init  = SUM_W'(base) * SUM_W'(SUBCOLUMNS);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= init;
      dlt_r <= delta;
    end else if (step) begin
      acc_r <= acc_r + SUM_W'(dlt_r);
    end
  end

  assign sum = acc_r;

endmodule

// ----- rtl/core/flhc_eval.sv -----
// ----------------------------------------------------------------------------
// flhc_eval
// projects one sub-column surface and forms its ridge, foreground and erase runs
// ----------------------------------------------------------------------------
module flhc_eval #(
  parameter int SUBCOLUMNS = 3,
  parameter int SUM_W      = 12,
  parameter int SURF_W     = 13,
  parameter int SUB_W      = 2
) (
  input  logic signed [SUM_W-1:0]  sum,
  input  logic [8:0]               depth,
  input  logic [7:0]               column,
  input  logic [SUB_W-1:0]         sub,
  input  logic signed [SURF_W-1:0] sky,
  input  logic [9:0]               row_origin,
  input  logic [9:0]               col_origin,
  output logic signed [SURF_W-1:0] surface,
  output flhc_pkg::eval_t          ev
);

  import flhc_pkg::*;

  localparam int ROW_W = SURF_W + 2;
  localparam int LEN_W = SURF_W + 2;

  logic signed [SUM_W-1:0] sum_adj;
  logic signed [SUM_W-1:0] h6;
  logic signed [SUM_W-1:0] ridge_q;
  logic signed [ROW_W-1:0] row_a;
  logic signed [ROW_W-1:0] row_b;
  logic signed [LEN_W-1:0] len_fg;
  logic signed [LEN_W-1:0] len_er;
  logic [10:0]             sx;
  logic [7:0]              ridge_c;
  logic                    front;
  logic                    h_pos;
  logic                    fg_pos;
  logic                    er_pos;

  function automatic logic [11:0] sat_row(input logic signed [ROW_W-1:0] r);
    logic [11:0] res;
    if (r < ROW_W'(-1024)) begin
      res = 12'h C00;
    end else if (r > ROW_W'(2047)) begin
      res = 12'h7FF;
    end else begin
      res = r[11:0];
    end
    return res;
  endfunction

  function automatic logic [10:0] sat_len(input logic signed [LEN_W-1:0] l);
    logic [10:0] res;
    if (l[LEN_W-1]) begin
      res = '0;
    end else if (l > LEN_W'(2047)) begin
      res = 11'h7FF;
    end else begin
      res = l[10:0];
    end
    return res;
  endfunction

  always_comb begin
    sum_adj = sum + signed'({{(SUM_W-1){1'b0}}, sum[SUM_W-1]});
    h6      = sum_adj >>> 1;
    surface = SURF_W'(signed'({1'b0, depth})) - SURF_W'(h6);
    front   = (depth == DEPTH_START);
    h_pos   = !h6[SUM_W-1] && (h6 != '0);

    sx    = 11'(col_origin) + 11'({3'b000, column} * 11'(SUBCOLUMNS)) + 11'(sub);
    row_a = ROW_W'(signed'({1'b0, row_origin})) + ROW_W'(surface);
    row_b = row_a + ROW_W'(1);

    len_fg = LEN_W'(signed'({1'b0, FG_BASE})) - LEN_W'(surface);
    len_er = LEN_W'(sky) - LEN_W'(surface) - LEN_W'(1);
    fg_pos = !len_fg[LEN_W-1] && (len_fg != '0);
    er_pos = !len_er[LEN_W-1] && (len_er != '0);

    ridge_q = (h6 >>> 2) + SUM_W'(signed'({1'b0, RIDGE_BIAS}));
    if (ridge_q > SUM_W'(signed'({1'b0, RIDGE_MAX}))) begin
      ridge_c = RIDGE_MAX;
    end else begin
      ridge_c = ridge_q[7:0];
    end

    ev.visible = (surface < sky);
    ev.has_a   = ev.visible && (front ? fg_pos : h_pos);
    ev.has_b   = ev.visible && !front && h_pos && er_pos;

    ev.run_a.col    = sx;
    ev.run_a.row    = sat_row(row_a);
    ev.run_a.len    = front ? sat_len(len_fg) : 11'd1;
    ev.run_a.colour = front ? FG_COLOUR : ridge_c;

    ev.run_b.col    = sx;
    ev.run_b.row    = sat_row(row_b);
    ev.run_b.len    = sat_len(len_er);
    ev.run_b.colour = ERASE_COLOUR;
  end

endmodule

// ----- rtl/core/floating_horizon_column_rasterizer.sv -----
// ----------------------------------------------------------------------------
// floating_horizon_column_rasterizer
// heightfield column rasterizer with a per sub-column floating horizon
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_wdata
//   in       in         in_valid / in_stall  column, depth, h00, h10, h01, h11
//   out      out        out_valid/out_stall  screen_col, screen_row, run_length,
//                                            colour, is_last
//
// one item takes one interpolator step per sub-column, each followed by the
// emit states for that sub-column's runs, then a flush state to close the item
// reset sets every skyline entry to 511 and the origins to 255 and 0
// a stalled out channel holds the run sequencer; in_stall is high while busy
// ----------------------------------------------------------------------------
module floating_horizon_column_rasterizer #(
  parameter int SUBCOLUMNS = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [flhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [flhc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_column,
  input  logic [8:0]                     in_depth,
  input  logic signed [7:0]              in_h00,
  input  logic signed [7:0]              in_h10,
  input  logic signed [7:0]              in_h01,
  input  logic signed [7:0]              in_h11,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [10:0]                    out_screen_col,
  output logic signed [11:0]             out_screen_row,
  output logic [10:0]                    out_run_length,
  output logic [7:0]                     out_colour,
  output logic                           out_is_last
);

  import flhc_pkg::*;

  localparam int SUM_W  = $clog2(4 * SUBCOLUMNS) + 8;
  localparam int SURF_W = SUM_W + 1;
  localparam int SUB_W  = $clog2(SUBCOLUMNS);
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(SUBCOLUMNS - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EVAL   = 5'b00010,
    ST_EMIT_A = 5'b00100,
    ST_EMIT_B = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_t;

  state_t                  state_r,  state_nxt;
  logic [SUB_W-1:0]        sub_r,    sub_nxt;
  logic [7:0]              col_r,    col_nxt;
  logic [8:0]              dep_r,    dep_nxt;
  logic [CFG_W-1:0]        row_org_r, row_org_nxt;
  logic [CFG_W-1:0]        col_org_r, col_org_nxt;
  run_t                    run_a_r,  run_a_nxt;
  run_t                    run_b_r,  run_b_nxt;
  logic                    has_b_r,  has_b_nxt;
  run_t                    pend_r,   pend_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  run_t                    out_run_r, out_run_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SURF_W-1:0] sky_r [SUBCOLUMNS];

  logic signed [SUM_W-1:0]  sum;
  logic signed [SURF_W-1:0] sky_cur;
  logic signed [SURF_W-1:0] surface;
  logic signed [SURF_W-1:0] sky_upd;
  eval_t                    ev;
  logic                     in_acc;
  logic                     out_free;
  logic                     can_push;
  logic                     push_req;
  run_t                     push_run;
  logic                     adv;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  flhc_interp #(
    .SUBCOLUMNS (SUBCOLUMNS),
    .SUM_W      (SUM_W)
  ) u_interp (
    .clk   (clk),
    .start (in_acc),
    .step  (state_r == ST_EVAL),
    .p     (in_depth[1:0]),
    .h00   (in_h00),
    .h10   (in_h10),
    .h01   (in_h01),
    .h11   (in_h11),
    .sum   (sum)
  );

  assign sky_cur = (dep_r == DEPTH_START) ? SURF_W'(signed'({1'b0, DEPTH_START}))
                                          : sky_r[sub_r];

  flhc_eval #(
    .SUBCOLUMNS (SUBCOLUMNS),
    .SUM_W      (SUM_W),
    .SURF_W     (SURF_W),
    .SUB_W      (SUB_W)
  ) u_eval (
    .sum        (sum),
    .depth      (dep_r),
    .column     (col_r),
    .sub        (sub_r),
    .sky        (sky_cur),
    .row_origin (row_org_r),
    .col_origin (col_org_r),
    .surface    (surface),
    .ev         (ev)
  );

  assign sky_upd = ev.visible ? surface : sky_cur;

  always_comb begin
    state_nxt      = state_r;
    sub_nxt        = sub_r;
    col_nxt        = col_r;
    dep_nxt        = dep_r;
    row_org_nxt    = row_org_r;
    col_org_nxt    = col_org_r;
    run_a_nxt      = run_a_r;
    run_b_nxt      = run_b_r;
    has_b_nxt      = has_b_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_run_nxt    = out_run_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r;
    push_req       = 1'b0;
    push_run       = run_a_r;
    adv            = 1'b0;

    out_free = !out_valid_r || !out_stall;
    can_push = !pend_valid_r || out_free;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_ROW_ORIGIN: row_org_nxt = cfg_wdata;
        REG_COL_ORIGIN: col_org_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          col_nxt   = in_column;
          dep_nxt   = in_depth;
          sub_nxt   = '0;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        run_a_nxt = ev.run_a;
        run_b_nxt = ev.run_b;
        has_b_nxt = ev.has_b;
        if (ev.has_a) begin
          state_nxt = ST_EMIT_A;
        end else begin
          adv = 1'b1;
        end
      end
      ST_EMIT_A: begin
        push_req = 1'b1;
        push_run = run_a_r;
        if (can_push) begin
          if (has_b_r) begin
            state_nxt = ST_EMIT_B;
          end else begin
            adv = 1'b1;
          end
        end
      end
      ST_EMIT_B: begin
        push_req = 1'b1;
        push_run = run_b_r;
        if (can_push) begin
          adv = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_run_nxt    = pend_r;
          out_last_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // older pending run leaves as not-last once a newer one shows up
    if (push_req && can_push) begin
      if (pend_valid_r) begin
        out_run_nxt   = pend_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = push_run;
      pend_valid_nxt = 1'b1;
    end

    if (adv) begin
      if (sub_r == SUB_LAST) begin
        state_nxt = ST_FLUSH;
      end else begin
        sub_nxt   = sub_r + SUB_W'(1);
        state_nxt = ST_EVAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      row_org_r    <= ROW_ORIGIN_RST;
      col_org_r    <= COL_ORIGIN_RST;
      sub_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      row_org_r    <= row_org_nxt;
      col_org_r    <= col_org_nxt;
      sub_r        <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    dep_r      <= dep_nxt;
    run_a_r    <= run_a_nxt;
    run_b_r    <= run_b_nxt;
    has_b_r    <= has_b_nxt;
    pend_r     <= pend_nxt;
    out_run_r  <= out_run_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SUBCOLUMNS; i++) begin
        sky_r[i] <= SURF_W'(signed'({1'b0, DEPTH_START}));
      end
    end else if (state_r == ST_EVAL) begin
      sky_r[sub_r] <= sky_upd;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_screen_col = out_run_r.col;
  assign out_screen_row = signed'(out_run_r.row);
  assign out_run_length = out_run_r.len;
  assign out_colour     = out_run_r.colour;
  assign out_is_last    = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("run still pending while idle");

  a_erase_not_front: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_B) |-> (dep_r != DEPTH_START))
    else $error("erase run at nearest depth");

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (sub_r <= SUB_LAST) && !(state_r == ST_FLUSH))
    else $error("sub-column index out of range");

  a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) && !pend_valid_r |=> (state_r == ST_IDLE))
    else $error("item did not close after last run");

endmodule

// ----- dv/floating_horizon_column_rasterizer_tb.sv -----
// ----------------------------------------------------------------------------
// floating_horizon_column_rasterizer_tb
// self-checking bench: a directed table of terrain cells, some rows with the
// draw runs typed in, then random column sweeps from depth 511 downward mixed
// with out-of-order depth noise, under several origin settings; every run is
// checked against an in-bench skyline predictor while both channels idle at
// random and the run sink holds off once for a long stretch
// ----------------------------------------------------------------------------
module floating_horizon_column_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import flhc_pkg::*;

  localparam int SUBCOLS      = 3;
  localparam int N_DIR        = 25;
  localparam int N_PHASES     = 5;
  localparam int PHASE_ITEMS  = 42;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int END_WAIT     = 5000;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [7:0] column;
    logic [8:0] depth;
    logic [7:0] h00;
    logic [7:0] h10;
    logic [7:0] h01;
    logic [7:0] h11;
  } cell_t;

  typedef struct packed {
    logic [10:0] col;
    logic [11:0] row;
    logic [10:0] len;
    logic [7:0]  colour;
    logic        last;
  } draw_run_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    cell_t                tile;
    logic                 typed;
    logic [1:0]           want_n;
    logic [10:0]          want_col;
    logic [11:0]          want_row;
    logic [10:0]          want_len;
    logic [7:0]           want_colour;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_column;
  logic [8:0]            in_depth;
  logic signed [7:0]     in_h00;
  logic signed [7:0]     in_h10;
  logic signed [7:0]     in_h01;
  logic signed [7:0]     in_h11;
  logic                  out_valid;
  logic                  out_stall;
  logic [10:0]           out_screen_col;
  logic signed [11:0]    out_screen_row;
  logic [10:0]           out_run_length;
  logic [7:0]            out_colour;
  logic                  out_is_last;

  draw_run_t             pending_runs[$];
  dir_row_t              dir_rows[N_DIR];
  int                    horizon_row[SUBCOLS];
  logic [CFG_W-1:0]      row_origin;
  logic [CFG_W-1:0]      col_origin;
  int                    n_mismatch;
  bit                    no_idle;
  bit                    hold_armed;

  floating_horizon_column_rasterizer #(
    .SUBCOLUMNS(SUBCOLS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_column      (in_column),
    .in_depth       (in_depth),
    .in_h00         (in_h00),
    .in_h10         (in_h10),
    .in_h01         (in_h01),
    .in_h11         (in_h11),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_screen_col (out_screen_col),
    .out_screen_row (out_screen_row),
    .out_run_length (out_run_length),
    .out_colour     (out_colour),
    .out_is_last    (out_is_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void queue_run(input int col, input int row, input int len,
                                    input int colour);
    draw_run_t r;
    if (row < -1024) row = -1024;
    if (row > 2047) row = 2047;
    if (len > 2047) len = 2047;
    if (len < 0) len = 0;
    r.col    = 11'(col);
    r.row    = 12'(row);
    r.len    = 11'(len);
    r.colour = 8'(colour);
    r.last   = 1'b0;
    pending_runs.push_back(r);
  endfunction

  // bilinear height per sub-column, projected against the skyline
  function automatic int trace_cell_runs(input cell_t c);
    int phase, wx0, wx1, acc, lift, surf, sky, sx, sy, tone, n;
    n = 0;
    phase = int'(c.depth[1:0]);
    for (int s = 0; s < SUBCOLS; s++) begin
      wx0 = SUBCOLS - s;
      wx1 = s;
      if (c.depth == DEPTH_START) horizon_row[s] = int'(DEPTH_START);
      acc = int'($signed(c.h00)) * wx0 * (4 - phase) + int'($signed(c.h10)) * wx1 * (4 - phase)
          + int'($signed(c.h01)) * wx0 * phase + int'($signed(c.h11)) * wx1 * phase;
      lift = acc / 2;
      surf = int'(c.depth) - lift;
      sky  = horizon_row[s];
      if (surf < sky) begin
        sx = int'(col_origin) + int'(c.column) * SUBCOLS + s;
        sy = int'(row_origin) + surf;
        if (c.depth == DEPTH_START) begin
          if (int'(FG_BASE) - surf > 0) begin
            queue_run(sx, sy, int'(FG_BASE) - surf, int'(FG_COLOUR));
            n++;
          end
        end else if (lift > 0) begin
          tone = lift / 4 + int'(RIDGE_BIAS);
          if (tone > int'(RIDGE_MAX)) tone = int'(RIDGE_MAX);
          queue_run(sx, sy, 1, tone);
          n++;
          if (sky - surf > 1) begin
            queue_run(sx, sy + 1, sky - surf - 1, int'(ERASE_COLOUR));
            n++;
          end
        end
        horizon_row[s] = surf;
      end
    end
    if (n > 0) pending_runs[pending_runs.size() - 1].last = 1'b1;
    return n;
  endfunction

  function automatic dir_row_t mk_item(input int col, input int dep, input int a, input int b,
                                       input int c, input int d);
    dir_row_t r;
    r = '0;
    r.kind        = ROW_ITEM;
    r.tile.column = 8'(col);
    r.tile.depth  = 9'(dep);
    r.tile.h00    = 8'(a);
    r.tile.h10    = 8'(b);
    r.tile.h01    = 8'(c);
    r.tile.h11    = 8'(d);
    return r;
  endfunction

  // flat cell: every sub-column yields the same run shape
  function automatic dir_row_t mk_typed(input int col, input int dep, input int h, input int n,
                                        input int ecol, input int erow, input int elen,
                                        input int ecolour);
    dir_row_t r;
    r = mk_item(col, dep, h, h, h, h);
    r.typed       = 1'b1;
    r.want_n      = 2'(n);
    r.want_col    = 11'(ecol);
    r.want_row    = 12'(erow);
    r.want_len    = 11'(elen);
    r.want_colour = 8'(ecolour);
    return r;
  endfunction

  function automatic dir_row_t mk_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    dir_row_t r;
    r = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = 10'(val);
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pick_origin();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_height(input int span);
    return 8'(int'($urandom_range(0, 2 * span - 1)) - span);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    n_mismatch++;
    if (n_mismatch <= 40)
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic check_run();
    draw_run_t want;
    if (pending_runs.size() == 0) begin
      flag_mismatch("run with none pending, screen_col", int'(out_screen_col), -1);
    end else begin
      want = pending_runs.pop_front();
      if (out_screen_col !== want.col)
        flag_mismatch("screen_col", int'(out_screen_col), int'(want.col));
      if (out_screen_row !== want.row)
        flag_mismatch("screen_row", int'(out_screen_row), int'($signed(want.row)));
      if (out_run_length !== want.len)
        flag_mismatch("run_length", int'(out_run_length), int'(want.len));
      if (out_colour !== want.colour)
        flag_mismatch("colour", int'(out_colour), int'(want.colour));
      if (out_is_last !== want.last)
        flag_mismatch("is_last", int'(out_is_last), int'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_run();
  end

  task automatic offer_cell(input cell_t c, output int n_runs);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_column <= c.column;
    in_depth  <= c.depth;
    in_h00    <= c.h00;
    in_h10    <= c.h10;
    in_h01    <= c.h01;
    in_h11    <= c.h11;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_runs = trace_cell_runs(c);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROW_ORIGIN: row_origin = val;
      REG_COL_ORIGIN: col_origin = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // column sweeps from the near edge outward, some with scrambled depths
  task automatic run_terrain(input int n_items);
    cell_t c;
    int left, seg, span, step, k, n;
    bit noisy;
    left = n_items;
    while (left > 0) begin
      noisy = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 2))
        0: span = 12;
        1: span = 64;
        default: span = 128;
      endcase
      seg = $urandom_range(2, 12);
      c.column = 8'($urandom_range(0, 255));
      c.depth  = DEPTH_START;
      for (k = 0; k < seg && left > 0; k++) begin
        if (noisy) c.depth = 9'($urandom);
        c.h00 = rand_height(span);
        c.h10 = rand_height(span);
        c.h01 = rand_height(span);
        c.h11 = rand_height(span);
        offer_cell(c, n);
        left--;
        step = $urandom_range(1, 48);
        c.depth = (int'(c.depth) > step) ? 9'(int'(c.depth) - step) : '0;
      end
    end
  endtask

  initial begin : sink_pacing
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, no_idle ? 1 : 24)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    dir_row_t  r;
    draw_run_t t;
    int        n, waited;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_column  <= '0;
    in_depth   <= '0;
    in_h00     <= '0;
    in_h10     <= '0;
    in_h01     <= '0;
    in_h11     <= '0;
    n_mismatch = 0;
    no_idle    = 1'b0;
    hold_armed = 1'b0;
    row_origin = ROW_ORIGIN_RST;
    col_origin = COL_ORIGIN_RST;
    for (int s = 0; s < SUBCOLS; s++) horizon_row[s] = int'(DEPTH_START);

    dir_rows = '{
      mk_typed(0, 511, 0, 0, 0, 0, 0, 0),                     // flat ground at the near edge
      mk_typed(0, 511, 127, 3, 0, 4, 764, 255),               // tallest foreground
      mk_typed(255, 511, -128, 0, 0, 0, 0, 0),                // deepest pit hidden
      mk_typed(255, 300, 0, 0, 0, 0, 0, 0),                   // visible, zero height
      mk_item(255, 0, 127, 127, 127, 127),                    // ridge and long erase
      mk_item(255, 0, -128, -128, -128, -128),
      mk_write(REG_ROW_ORIGIN, 1023),
      mk_write(REG_COL_ORIGIN, 1023),
      mk_typed(255, 511, 127, 3, 1788, 772, 764, 255),        // both origins at max
      mk_item(255, 300, 127, -128, -128, 127),
      mk_item(255, 301, 127, -128, -128, 127),
      mk_item(255, 302, 127, -128, -128, 127),
      mk_item(255, 303, 127, -128, -128, 127),
      mk_item(85, 6, 1, 0, 0, 0),                             // odd sums round toward zero
      mk_item(85, 5, -1, 0, 0, -1),
      mk_item(170, 170, 0, 127, -128, 0),
      mk_write(REG_SPARE_A, 5),                               // unmapped writes ignored
      mk_write(REG_SPARE_B, 1023),
      mk_write(REG_ROW_ORIGIN, 0),
      mk_write(REG_COL_ORIGIN, 0),
      mk_typed(128, 511, 127, 3, 384, -251, 764, 255),        // row goes negative
      mk_typed(128, 108, 60, 3, 384, -252, 1, 92),            // ridge right above skyline
      mk_item(128, 100, 64, 64, 64, 64),
      mk_typed(128, 100, 64, 0, 0, 0, 0, 0),                  // level with skyline
      mk_item(0, 255, 1, -1, 2, -2)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      r = dir_rows[i];
      if (r.kind == ROW_WRITE) begin
        drain_block();
        write_reg(r.reg_idx, r.reg_val);
      end else begin
        offer_cell(r.tile, n);
        if (r.typed) begin
          repeat (n) void'(pending_runs.pop_back());
          for (int s = 0; s < int'(r.want_n); s++) begin
            t.col    = r.want_col + 11'(s);
            t.row    = r.want_row;
            t.len    = r.want_len;
            t.colour = r.want_colour;
            t.last   = (s == int'(r.want_n) - 1);
            pending_runs.push_back(t);
          end
        end
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_block();
      no_idle = (ph == N_PHASES - 1);
      write_reg(REG_ROW_ORIGIN, pick_origin());
      write_reg(REG_COL_ORIGIN, pick_origin());
      if ($urandom_range(0, 1) == 1)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 10'($urandom));
      if (ph == 1) hold_armed = 1'b1;
      run_terrain(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_runs.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_runs.size() != 0) begin
      flag_mismatch("runs never arrived", int'(pending_runs.size()), 0);
    end
    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- floating_horizon_column_rasterizer.f -----
rtl/core/flhc_pkg.sv
rtl/core/flhc_interp.sv
rtl/core/flhc_eval.sv
rtl/core/floating_horizon_column_rasterizer.sv
dv/floating_horizon_column_rasterizer_tb.sv
